// ===== hw/rtl/afc_pkg.sv =====
package afc_pkg;

  // defaults for the top-level parameters
  localparam int NUM_PLANES_DEF = 6;
  localparam int COORD_BITS_DEF = 16;

  // plane register file
  localparam int PLANE_REGS = 6;
  localparam int REG_W      = 64;
  localparam int ADDR_W     = 6;
  localparam int IDX_W      = 3;
  localparam int IDX_LSB    = 3;

  // packed plane coefficients: nx, ny, nz Q2.14 and w int16, lowest first
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int AXES      = 3;

  typedef logic [REG_W-1:0] plane_t;

  typedef enum logic [IDX_W-1:0] {
    REG_PLANE_RIGHT  = 3'd0,
    REG_PLANE_LEFT   = 3'd1,
    REG_PLANE_TOP    = 3'd2,
    REG_PLANE_BOTTOM = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5
  } reg_idx_t;

endpackage

// ===== hw/rtl/aabb_frustum_cull.sv =====
// channel   direction  handshake          payload
// in_       input      in_valid/in_ready   box_min_{x,y,z}, box_max_{x,y,z}
// out_      output     out_valid/out_ready out_visible
// cfg       apb r/w    psel/penable/pwrite paddr, pwdata, prdata (pready tied high)
//
// one box per cycle sustained while out_ready is high; two register stages in
// each plane cell (multiply, then sum and sign)
// synchronous active-low reset clears the valid bits and the plane registers
// every stage moves when it is empty or its successor moves, so bubbles
// close up and new boxes are taken while a result waits at the output
module aabb_frustum_cull
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = NUM_PLANES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // box input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_box_min_x,
  input  logic [COORD_BITS-1:0] in_box_min_y,
  input  logic [COORD_BITS-1:0] in_box_min_z,
  input  logic [COORD_BITS-1:0] in_box_max_x,
  input  logic [COORD_BITS-1:0] in_box_max_y,
  input  logic [COORD_BITS-1:0] in_box_max_z,
  // cull result
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_visible,
  // plane registers, 64-bit each at 8-byte spacing
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [REG_W-1:0]      pwdata,
  output logic [REG_W-1:0]      prdata,
  output logic                  pready
);

  plane_t [PLANE_REGS-1:0] planes;

  // chain links: index 0 is the input side, NUM_PLANES the output side
  logic [NUM_PLANES:0]                        link_valid;
  logic [NUM_PLANES:0]                        link_ready;
  logic [NUM_PLANES:0]                        link_culled;
  logic [NUM_PLANES:0][AXES-1:0][COORD_BITS-1:0] link_lo, link_hi;

  afc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .planes  (planes)
  );

  // box enters the chain with nothing culled yet
  assign link_valid[0]  = in_valid;
  assign in_ready       = link_ready[0];
  assign link_culled[0] = 1'b0;
  assign link_lo[0]     = {in_box_min_z, in_box_min_y, in_box_min_x};
  assign link_hi[0]     = {in_box_max_z, in_box_max_y, in_box_max_x};

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    plane_t cell_plane;

    // planes past the register file hold zero and never cull
    if (i < PLANE_REGS) begin : g_reg
      assign cell_plane = planes[i];
    end else begin : g_zero
      assign cell_plane = '0;
    end

    afc_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .plane      (cell_plane),
      .in_valid   (link_valid[i]),
      .in_ready   (link_ready[i]),
      .in_lo      (link_lo[i]),
      .in_hi      (link_hi[i]),
      .in_culled  (link_culled[i]),
      .out_valid  (link_valid[i+1]),
      .out_ready  (link_ready[i+1]),
      .out_lo     (link_lo[i+1]),
      .out_hi     (link_hi[i+1]),
      .out_culled (link_culled[i+1])
    );
  end

  // last cell's stage b register is the output register
  assign out_valid              = link_valid[NUM_PLANES];
  assign link_ready[NUM_PLANES] = out_ready;
  assign out_visible            = !link_culled[NUM_PLANES];

endmodule

// ===== hw/rtl/afc_regs.sv =====
module afc_regs
  import afc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [REG_W-1:0]             pwdata,
  output logic [REG_W-1:0]             prdata,
  output logic                         pready,
  output plane_t [PLANE_REGS-1:0]      planes
);

  plane_t [PLANE_REGS-1:0] plane_r;
  logic [IDX_W-1:0]        idx;
  logic                    wr_en;

  assign idx   = paddr[IDX_LSB +: IDX_W];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign planes = plane_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (wr_en && idx <= REG_PLANE_FAR) begin
      plane_r[idx] <= pwdata;
    end
  end

  // readback; unused slots read zero
  always_comb begin
    prdata = '0;
    if (idx <= REG_PLANE_FAR) begin
      prdata = plane_r[idx];
    end
  end

endmodule

// ===== hw/rtl/afc_cell.sv =====
module afc_cell
  import afc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  plane_t                           plane,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [AXES-1:0][COORD_BITS-1:0]  in_lo,
  input  logic [AXES-1:0][COORD_BITS-1:0]  in_hi,
  input  logic                             in_culled,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [AXES-1:0][COORD_BITS-1:0]  out_lo,
  output logic [AXES-1:0][COORD_BITS-1:0]  out_hi,
  output logic                             out_culled
);

  localparam int PROD_W = COORD_BITS + COEF_W;
  localparam int SUM_W  = (COORD_BITS + 18 > 31) ? COORD_BITS + 18 : 31;

  // stage a: corner pick and products
  logic                                 valid_a_r;
  logic [AXES-1:0][COORD_BITS-1:0]      lo_a_r, hi_a_r;
  logic                                 culled_a_r;
  logic [AXES-1:0][PROD_W-1:0]          prod_a_r;
  logic [COEF_W-1:0]                    w_a_r;
  // stage b: distance sign
  logic                                 valid_b_r;
  logic [AXES-1:0][COORD_BITS-1:0]      lo_b_r, hi_b_r;
  logic                                 culled_b_r;

  logic                                 en_a, en_b;
  logic [AXES-1:0][PROD_W-1:0]          prod_nxt;
  logic signed [SUM_W-1:0]              dist_sum;

  assign en_b     = !valid_b_r || out_ready;
  assign en_a     = !valid_a_r || en_b;
  assign in_ready = en_a;

  // the corner farthest along the normal gives the largest distance
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      logic signed [COORD_BITS-1:0] lo_s, hi_s, pick;
      logic signed [COEF_W-1:0]     n;
      logic signed [PROD_W-1:0]     x_ext, n_ext;
      lo_s  = $signed(in_lo[k]);
      hi_s  = $signed(in_hi[k]);
      n     = $signed(plane[k*COEF_W +: COEF_W]);
      pick  = (n[COEF_W-1] ^ (hi_s >= lo_s)) ? hi_s : lo_s;
      x_ext = PROD_W'(pick);
      n_ext = PROD_W'(n);
      prod_nxt[k] = x_ext * n_ext;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] w_term;
    w_term = {{(SUM_W-COEF_W-FRAC_BITS){w_a_r[COEF_W-1]}}, w_a_r, {FRAC_BITS{1'b0}}};
    dist_sum = w_term;
    for (int k = 0; k < AXES; k++) begin
      dist_sum = dist_sum + {{(SUM_W-PROD_W){prod_a_r[k][PROD_W-1]}}, prod_a_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (en_a) valid_a_r <= in_valid;
      if (en_b) valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      lo_a_r     <= in_lo;
      hi_a_r     <= in_hi;
      culled_a_r <= in_culled;
      prod_a_r   <= prod_nxt;
      w_a_r      <= plane[AXES*COEF_W +: COEF_W];
    end
    if (en_b) begin
      lo_b_r     <= lo_a_r;
      hi_b_r     <= hi_a_r;
      culled_b_r <= culled_a_r || dist_sum[SUM_W-1];
    end
  end

  assign out_valid  = valid_b_r;
  assign out_lo     = lo_b_r;
  assign out_hi     = hi_b_r;
  assign out_culled = culled_b_r;

endmodule
